[rtl/core/fragment_reassembly_table_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef FRAGMENT_REASSEMBLY_TABLE_TOP_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TABLE_TOP_MACROS_SVH

// Assert a property on the rising clock, quiet while reset is held.
`define FRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle.
`define FRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  `FRT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/core/frt_pkg.sv]
package frt_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RUN_W    = $clog2(SLOTS + 1);
  localparam int AW       = 9;  // wide enough for slot + 8-bit position/count
  localparam logic [16:0] MSG_MAX = 17'h1FFFF;

  localparam logic [1:0] OP_ASSEMBLE = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_RESET    = 2'd2;

  localparam logic [1:0] ST_REJECT   = 2'd0;
  localparam logic [1:0] ST_STORED   = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  typedef enum logic [1:0] {
    K_ASM,
    K_CLR,
    K_RST,
    K_REJ
  } kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SEARCH,
    B_ZERO,
    B_MATCH,
    B_WRITE,
    B_CHECK,
    B_DONE
  } back_state_e;

  typedef struct packed {
    kind_e        kind;
    logic [15:0]  peer_counter;
    logic [15:0]  peer_ident;
    logic [63:0]  sequence_req;
    logic [12:0]  frag_bytes;
    logic [7:0]   frag_index;
    logic [7:0]   frag_total;
    logic [3:0]   entry_index;
  } entry_t;

endpackage

[rtl/core/frt_front.sv]
module frt_front (
  input  logic [1:0]           op_i,
  input  logic [15:0]          peer_counter_i,
  input  logic [15:0]          peer_ident_i,
  input  logic [63:0]          sequence_req_i,
  input  logic [12:0]          frag_bytes_i,
  input  logic [7:0]           frag_index_i,
  input  logic [7:0]           frag_total_i,
  input  logic [3:0]           entry_index_i,
  input  logic [12:0]          slot_bytes_i,
  output frt_pkg::entry_t      entry_o
);
  import frt_pkg::*;

  logic bad;

  // Field checks for an assemble item.
  assign bad = (frag_total_i == 8'd0) || (frag_index_i >= frag_total_i) ||
               (frag_bytes_i == 13'd0) || (frag_bytes_i > slot_bytes_i) ||
               ((frag_bytes_i != slot_bytes_i) &&
                ({1'b0, frag_index_i} + 9'd1 != {1'b0, frag_total_i}));

  always_comb begin
    entry_o.peer_counter = peer_counter_i;
    entry_o.peer_ident   = peer_ident_i;
    entry_o.sequence_req = sequence_req_i;
    entry_o.frag_bytes   = frag_bytes_i;
    entry_o.frag_index   = frag_index_i;
    entry_o.frag_total   = frag_total_i;
    entry_o.entry_index  = entry_index_i;
    case (op_i)
      OP_ASSEMBLE: entry_o.kind = bad ? K_REJ : K_ASM;
      OP_CLEAR:    entry_o.kind = K_CLR;
      OP_RESET:    entry_o.kind = K_RST;
      default:     entry_o.kind = K_REJ;
    endcase
  end

endmodule

[rtl/core/frt_queue.sv]
module frt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  frt_pkg::entry_t data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output frt_pkg::entry_t data_o
);
  import frt_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

[rtl/core/frt_back.sv]
module frt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  frt_pkg::entry_t entry_i,
  input  logic [12:0]     slot_bytes_i,
  output logic            pop_o,
  output logic            done_o,
  output logic [1:0]      status_o,
  output logic [3:0]      write_slot_o,
  output logic [3:0]      message_id_o,
  output logic [16:0]     message_bytes_o
);
  import frt_pkg::*;

  back_state_e state_q, state_d;
  entry_t      item_q, item_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [SLOT_W-1:0] id_q, id_d;
  logic [16:0]       total_q, total_d;
  logic              ok_q, ok_d;
  logic [RUN_W-1:0]  alloc_q;

  logic [RUN_W-1:0]  run_q [SLOTS];
  logic [15:0]       pc_q  [SLOTS];
  logic [15:0]       pi_q  [SLOTS];
  logic [63:0]       sq_q  [SLOTS];
  logic [12:0]       fb_q  [SLOTS];
  logic [16:0]       mb_q  [SLOTS];

  logic              emit;
  logic [1:0]        st_d;
  logic [3:0]        ws_d, mid_d;
  logic [16:0]       mbytes_d;
  logic              clr_en, rst_en, zero_en, head_en, fb_en, mb_en;
  logic [SLOT_W-1:0] zero_idx, fb_idx;

  logic [AW-1:0]     id_w, cnt_w, pos_w, alloc_w, slot_w, last_w;
  logic [SLOT_W-1:0] rd_idx;
  logic [17:0]       sum;
  logic [12:0]       add_v;
  logic [16:0]       msg;

  assign id_w    = AW'(id_q);
  assign cnt_w   = AW'(item_q.frag_total);
  assign pos_w   = AW'(item_q.frag_index);
  assign alloc_w = AW'(alloc_q);
  assign slot_w  = id_w + idx_q;
  assign last_w  = cnt_w - AW'(1);
  assign rd_idx  = (state_q == B_SEARCH) ? idx_q[SLOT_W-1:0] : slot_w[SLOT_W-1:0];

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    idx_d    = idx_q;
    id_d     = id_q;
    total_d  = total_q;
    ok_d     = ok_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    st_d     = ST_REJECT;
    ws_d     = 4'd0;
    mid_d    = 4'd0;
    mbytes_d = 17'd0;
    clr_en   = 1'b0;
    rst_en   = 1'b0;
    zero_en  = 1'b0;
    head_en  = 1'b0;
    fb_en    = 1'b0;
    mb_en    = 1'b0;
    zero_idx = slot_w[SLOT_W-1:0];
    fb_idx   = SLOT_W'(id_w + pos_w);
    add_v    = 13'd0;
    sum      = 18'd0;
    msg      = 17'd0;
    case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          case (entry_i.kind)
            K_CLR: begin
              clr_en = (AW'(entry_i.entry_index) < AW'(SLOTS));
              zero_idx = SLOT_W'(entry_i.entry_index);
              emit = 1'b1;
              st_d = ST_DONE;
            end
            K_RST: begin
              rst_en = 1'b1;
              emit = 1'b1;
              st_d = ST_DONE;
            end
            K_ASM: begin
              item_d  = entry_i;
              idx_d   = '0;
              state_d = B_SEARCH;
            end
            default: begin
              emit = 1'b1;
              st_d = ST_REJECT;
            end
          endcase
        end
      end
      B_SEARCH: begin
        if (run_q[rd_idx] != '0 && pc_q[rd_idx] == item_q.peer_counter &&
            pi_q[rd_idx] == item_q.peer_ident && sq_q[rd_idx] == item_q.sequence_req) begin
          id_d    = rd_idx;
          state_d = B_MATCH;
        end else if (idx_q == AW'(SLOTS - 1)) begin
          if (cnt_w > AW'(SLOTS)) begin
            emit    = 1'b1;
            state_d = B_IDLE;
          end else begin
            id_d    = (alloc_w + cnt_w <= AW'(SLOTS)) ? alloc_q[SLOT_W-1:0] : '0;
            idx_d   = '0;
            state_d = B_ZERO;
          end
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      B_ZERO: begin
        zero_en = 1'b1;
        if (idx_q == last_w) begin
          head_en = 1'b1;
          state_d = B_WRITE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      B_MATCH: begin
        if (AW'(run_q[id_q]) != cnt_w || id_w + pos_w >= AW'(SLOTS)) begin
          emit    = 1'b1;
          state_d = B_IDLE;
        end else begin
          state_d = B_WRITE;
        end
      end
      B_WRITE: begin
        fb_en   = 1'b1;
        idx_d   = '0;
        total_d = '0;
        ok_d    = 1'b1;
        state_d = (id_w + cnt_w > AW'(SLOTS)) ? B_DONE : B_CHECK;
        if (id_w + cnt_w > AW'(SLOTS)) ok_d = 1'b0;
      end
      B_CHECK: begin
        if (idx_q == last_w) begin
          ok_d  = ok_q && (fb_q[rd_idx] != 13'd0);
          add_v = fb_q[rd_idx];
          state_d = B_DONE;
        end else begin
          ok_d  = ok_q && (fb_q[rd_idx] == slot_bytes_i);
          add_v = slot_bytes_i;
          idx_d = idx_q + AW'(1);
        end
        sum     = {1'b0, total_q} + 18'(add_v);
        total_d = (sum > 18'(MSG_MAX)) ? MSG_MAX : sum[16:0];
      end
      B_DONE: begin
        mb_en = ok_q;
        msg   = ok_q ? total_q : mb_q[id_q];
        emit  = 1'b1;
        st_d  = (msg != 17'd0) ? ST_COMPLETE : ST_STORED;
        ws_d  = 4'(id_w + pos_w);
        mid_d = 4'(id_w);
        mbytes_d = msg;
        state_d  = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      done_o  <= 1'b0;
      alloc_q <= '0;
      for (int i = 0; i < SLOTS; i++) run_q[i] <= '0;
    end else begin
      state_q <= state_d;
      done_o  <= emit;
      if (rst_en) begin
        alloc_q <= '0;
        for (int i = 0; i < SLOTS; i++) run_q[i] <= '0;
      end
      if (clr_en || zero_en) run_q[zero_idx] <= '0;
      if (head_en) begin
        run_q[id_q] <= RUN_W'(cnt_w);
        alloc_q     <= RUN_W'(id_w + cnt_w);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    idx_q   <= idx_d;
    id_q    <= id_d;
    total_q <= total_d;
    ok_q    <= ok_d;
    status_o        <= st_d;
    write_slot_o    <= ws_d;
    message_id_o    <= mid_d;
    message_bytes_o <= mbytes_d;
    if (clr_en || zero_en) begin
      fb_q[zero_idx] <= '0;
      mb_q[zero_idx] <= '0;
    end
    if (head_en) begin
      pc_q[id_q] <= item_q.peer_counter;
      pi_q[id_q] <= item_q.peer_ident;
      sq_q[id_q] <= item_q.sequence_req;
    end
    if (fb_en) fb_q[fb_idx] <= item_q.frag_bytes;
    if (mb_en) mb_q[id_q] <= total_q;
  end

endmodule

[rtl/core/fragment_reassembly_table_top.sv]
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-----------------------------------
// item      | in        | start high, busy low      | op, peer key, sequence, fragment
// result    | out       | done_o strobe, one cycle  | status, write_slot, message_id, bytes
// config    | in        | cfg_valid_i && cfg_ready_o| slot_bytes (13 bit)
//
// A new message is popped, searched over all slots, cleared over its run, recorded,
// checked fragment by fragment and reported; a fragment of a live message is searched
// to its slot, matched, recorded, checked and reported, or reported after the match on
// a count or range mismatch; too long a run is reported after the search; clear, reset
// and field-rejected items are reported on pop. A queued item waits for the one ahead.
// Reset is asynchronous and active low; it empties the run counts and the allocation
// position. The receiver cannot stall; busy rises only while the two-entry queue is full.
module fragment_reassembly_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] peer_counter_i,
  input  logic [15:0] peer_ident_i,
  input  logic [63:0] sequence_req_i,
  input  logic [12:0] frag_bytes_i,
  input  logic [7:0]  frag_index_i,
  input  logic [7:0]  frag_total_i,
  input  logic [3:0]  entry_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_slot_bytes_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  write_slot_o,
  output logic [3:0]  message_id_o,
  output logic [16:0] message_bytes_o
);
  import frt_pkg::*;

  logic [12:0] slot_bytes_q;
  entry_t      front_entry, queue_entry;
  logic        q_valid, q_full, q_pop, push;

  // Take a write on any cycle; write only while no item is in flight.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q <= 13'd1024;
    end else if (cfg_valid_i) begin
      slot_bytes_q <= cfg_slot_bytes_i;
    end
  end

  // Hold off new items only while the queue is full.
  assign busy = q_full;
  assign push = start && !q_full;

  // Classify the item: decode the op and check the fragment fields.
  frt_front u_front (
    .op_i           (op_i),
    .peer_counter_i (peer_counter_i),
    .peer_ident_i   (peer_ident_i),
    .sequence_req_i (sequence_req_i),
    .frag_bytes_i   (frag_bytes_i),
    .frag_index_i   (frag_index_i),
    .frag_total_i   (frag_total_i),
    .entry_index_i  (entry_index_i),
    .slot_bytes_i   (slot_bytes_q),
    .entry_o        (front_entry)
  );

  // Decouple the front from the table sequencer.
  frt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (queue_entry)
  );

  // Search, allocate, record and check completion, one slot per cycle.
  frt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .entry_i         (queue_entry),
    .slot_bytes_i    (slot_bytes_q),
    .pop_o           (q_pop),
    .done_o          (done_o),
    .status_o        (status_o),
    .write_slot_o    (write_slot_o),
    .message_id_o    (message_id_o),
    .message_bytes_o (message_bytes_o)
  );

endmodule

[rtl/core/frt_checker.sv]
`include "fragment_reassembly_table_top_macros.svh"

module frt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [3:0]  write_slot_o,
  input logic [3:0]  message_id_o,
  input logic [16:0] message_bytes_o
);
  import frt_pkg::*;

  logic complete, nonfinal, stored, unstored, slot_zero;

  assign complete  = done_o && (status_o == ST_COMPLETE);
  assign nonfinal  = done_o && !complete;
  assign stored    = done_o && (status_o inside {ST_STORED, ST_COMPLETE});
  assign unstored  = done_o && (status_o inside {ST_REJECT, ST_DONE});
  assign slot_zero = (write_slot_o == 4'd0) && (message_id_o == 4'd0);

  `FRT_ASSERT_IMPL(a_bytes_only_complete, nonfinal, message_bytes_o == 17'd0, "stray length")
  `FRT_ASSERT_IMPL(a_complete_nonzero, complete, message_bytes_o != 17'd0, "zero length")
  `FRT_ASSERT_IMPL(a_slot_zero_unstored, unstored, slot_zero, "slot on unstored result")
  `FRT_ASSERT_IMPL(a_slot_in_run, stored, write_slot_o >= message_id_o, "slot before start")

endmodule

bind fragment_reassembly_table_top frt_checker u_frt_checker (.*);
